### hw/rtl/nsho_pkg.sv
// Shared types, constants and ECC functions of the NAND sector spare-area generator.
package nsho_pkg;

    localparam int DATA_W    = 8;
    localparam int SECTOR_W  = 16;
    localparam int POS_W     = 9;
    localparam int OOB_IDX_W = 4;

    localparam logic [POS_W-1:0]     POS_HALF_END = 9'd255;
    localparam logic [POS_W-1:0]     POS_LAST     = 9'd511;
    localparam logic [OOB_IDX_W-1:0] OOB_LAST     = 4'd15;

    // spare-area slot codes
    localparam logic [OOB_IDX_W-1:0] SLOT_A0 = 4'd0;
    localparam logic [OOB_IDX_W-1:0] SLOT_A1 = 4'd1;
    localparam logic [OOB_IDX_W-1:0] SLOT_A2 = 4'd2;
    localparam logic [OOB_IDX_W-1:0] SLOT_B0 = 4'd3;
    localparam logic [OOB_IDX_W-1:0] SLOT_P0 = 4'd4;
    localparam logic [OOB_IDX_W-1:0] SLOT_P1 = 4'd5;
    localparam logic [OOB_IDX_W-1:0] SLOT_B1 = 4'd6;
    localparam logic [OOB_IDX_W-1:0] SLOT_B2 = 4'd7;

    localparam logic [DATA_W-1:0] FILL_BYTE = 8'hFF;

    typedef logic [DATA_W-1:0] t_byte;

    localparam t_byte MARKER [8] = '{8'h19, 8'h85, 8'h20, 8'h03,
                                     8'h00, 8'h00, 8'h00, 8'h08};

    typedef struct packed {
        t_byte                a0;
        t_byte                a1;
        t_byte                a2;
        t_byte                b0;
        t_byte                b1;
        t_byte                b2;
        logic [SECTOR_W-1:0]  sector;
    } t_rec;

    // column parity CP0..CP5 in bits 5:0, byte parity in bit 6
    function automatic t_byte col_pattern(input t_byte b);
        t_byte r;
        r    = '0;
        r[0] = ^(b & 8'h55);
        r[1] = ^(b & 8'hAA);
        r[2] = ^(b & 8'h33);
        r[3] = ^(b & 8'hCC);
        r[4] = ^(b & 8'h0F);
        r[5] = ^(b & 8'hF0);
        r[6] = ^b;
        return r;
    endfunction

    // 3-byte ECC of one 256-byte half, first byte in bits 23:16
    function automatic logic [23:0] half_ecc(input t_byte cp, input t_byte lp);
        t_byte odd;
        t_byte even;
        t_byte hi;
        t_byte lo;
        odd  = lp;
        even = cp[6] ? ~lp : lp;
        hi   = '0;
        lo   = '0;
        for (int i = 0; i < 4; i++) begin
            hi[7-2*i] = odd[7-i];
            hi[6-2*i] = even[7-i];
            lo[7-2*i] = odd[3-i];
            lo[6-2*i] = even[3-i];
        end
        return {~hi, ~lo, ~cp[5:0], 2'b11};
    endfunction

endpackage

### hw/rtl/nsho_if.sv
// Valid/ready channel interfaces for sector data in and spare bytes out.
interface nsho_in_if;
    logic                           valid;
    logic                           ready;
    logic [nsho_pkg::DATA_W-1:0]    data_byte;
    logic [nsho_pkg::SECTOR_W-1:0]  sector_number;

    modport source (output valid, output data_byte, output sector_number, input ready);
    modport sink   (input valid, input data_byte, input sector_number, output ready);
endinterface

interface nsho_out_if;
    logic                            valid;
    logic                            ready;
    logic [nsho_pkg::DATA_W-1:0]     oob_byte;
    logic [nsho_pkg::OOB_IDX_W-1:0]  oob_index;
    logic                            oob_last;

    modport source (output valid, output oob_byte, output oob_index, output oob_last,
                    input ready);
    modport sink   (input valid, input oob_byte, input oob_index, input oob_last,
                    output ready);
endinterface

### hw/rtl/nsho_ecc_acc.sv
// Per-half column/line parity accumulation and ECC record build.
module nsho_ecc_acc (
    input  logic            i_clk,
    input  logic            i_rst_n,
    nsho_in_if.sink         i_in,
    output nsho_pkg::t_rec  o_rec,
    output logic            o_rec_valid,
    input  logic            i_rec_ready
);

    logic [nsho_pkg::POS_W-1:0] r_pos, n_pos;
    nsho_pkg::t_byte            r_cp, n_cp;
    nsho_pkg::t_byte            r_lp, n_lp;
    logic [23:0]                r_first, n_first;

    nsho_pkg::t_byte pat;
    nsho_pkg::t_byte cp_upd;
    nsho_pkg::t_byte lp_upd;
    logic [23:0]     ecc_now;
    logic            fire;

    // last byte of a sector waits until the drain can take the record
    assign i_in.ready = (r_pos != nsho_pkg::POS_LAST) || i_rec_ready;
    assign fire       = i_in.valid && i_in.ready;

    always_comb begin
        pat     = nsho_pkg::col_pattern(i_in.data_byte);
        cp_upd  = r_cp ^ pat;
        lp_upd  = pat[6] ? (r_lp ^ r_pos[7:0]) : r_lp;
        ecc_now = nsho_pkg::half_ecc(cp_upd, lp_upd);
    end

    always_comb begin
        n_pos   = r_pos;
        n_cp    = r_cp;
        n_lp    = r_lp;
        n_first = r_first;
        if (fire) begin
            n_pos = r_pos + 9'd1;
            if (r_pos[7:0] == nsho_pkg::POS_HALF_END[7:0]) begin
                n_cp = '0;
                n_lp = '0;
                if (r_pos == nsho_pkg::POS_HALF_END) begin
                    n_first = ecc_now;
                end
            end else begin
                n_cp = cp_upd;
                n_lp = lp_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_cp    <= '0;
            r_lp    <= '0;
            r_first <= '0;
        end else begin
            r_pos   <= n_pos;
            r_cp    <= n_cp;
            r_lp    <= n_lp;
            r_first <= n_first;
        end
    end

    assign o_rec_valid  = fire && (r_pos == nsho_pkg::POS_LAST);
    assign o_rec.a0     = r_first[23:16];
    assign o_rec.a1     = r_first[15:8];
    assign o_rec.a2     = r_first[7:0];
    assign o_rec.b0     = ecc_now[23:16];
    assign o_rec.b1     = ecc_now[15:8];
    assign o_rec.b2     = ecc_now[7:0];
    assign o_rec.sector = i_in.sector_number;

endmodule

### hw/rtl/nsho_oob_drain.sv
// Spare-area record register, marker check and 16-byte serializer.
module nsho_oob_drain #(
    parameter int MARKER_INTERVAL = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  nsho_pkg::t_rec  i_rec,
    input  logic            i_rec_valid,
    output logic            o_rec_ready,
    nsho_out_if.source      o_out
);

    // sector % interval == 0 via reciprocal multiply, exact for 16-bit sectors
    localparam int SHIFT = nsho_pkg::SECTOR_W + $clog2(MARKER_INTERVAL);
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(MARKER_INTERVAL) - 64'd1) / 64'(MARKER_INTERVAL);
    localparam logic [17:0] RECIP = 18'(RECIP_FULL);
    localparam logic [16:0] MODV  = 17'(MARKER_INTERVAL);

    logic                           r_busy;
    logic [nsho_pkg::OOB_IDX_W-1:0] r_idx;
    nsho_pkg::t_rec                 r_rec;
    logic [nsho_pkg::SECTOR_W-1:0]  r_q;
    logic                           r_mark;

    logic        out_fire;
    logic [33:0] scaled;
    logic [32:0] back_prod;

    assign out_fire    = r_busy && o_out.ready;
    assign o_rec_ready = !r_busy || (o_out.ready && (r_idx == nsho_pkg::OOB_LAST));

    assign scaled    = 34'(i_rec.sector) * 34'(RECIP);
    assign back_prod = 33'(r_q) * 33'(MODV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (i_rec_valid) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (out_fire) begin
                r_idx <= r_idx + 4'd1;
                if (r_idx == nsho_pkg::OOB_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // payload, no reset; marker flag settles long before slot 8
    always_ff @(posedge i_clk) begin
        if (i_rec_valid) begin
            r_rec <= i_rec;
            r_q   <= 16'(scaled >> SHIFT);
        end
        r_mark <= (back_prod == 33'(r_rec.sector));
    end

    always_comb begin
        case (r_idx)
            nsho_pkg::SLOT_A0: o_out.oob_byte = r_rec.a0;
            nsho_pkg::SLOT_A1: o_out.oob_byte = r_rec.a1;
            nsho_pkg::SLOT_A2: o_out.oob_byte = r_rec.a2;
            nsho_pkg::SLOT_B0: o_out.oob_byte = r_rec.b0;
            nsho_pkg::SLOT_P0: o_out.oob_byte = nsho_pkg::FILL_BYTE;
            nsho_pkg::SLOT_P1: o_out.oob_byte = nsho_pkg::FILL_BYTE;
            nsho_pkg::SLOT_B1: o_out.oob_byte = r_rec.b1;
            nsho_pkg::SLOT_B2: o_out.oob_byte = r_rec.b2;
            default: o_out.oob_byte = r_mark ? nsho_pkg::MARKER[r_idx[2:0]]
                                             : nsho_pkg::FILL_BYTE;
        endcase
    end

    assign o_out.valid     = r_busy;
    assign o_out.oob_index = r_idx;
    assign o_out.oob_last  = (r_idx == nsho_pkg::OOB_LAST);

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rec_valid |-> o_rec_ready)
        else $error("record loaded while spare area still draining");

    a_load_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rec_valid |=> (r_busy && (r_idx == '0)))
        else $error("record load did not restart at slot zero");

    a_idx_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && (r_idx != nsho_pkg::OOB_LAST)) |=>
            (r_busy && (r_idx == 4'($past(r_idx) + 4'd1))))
        else $error("spare slot index did not advance by one");

endmodule

### hw/rtl/nand_sector_hamming_oob_core.sv
// Top level: NAND sector Hamming ECC spare-area generator.
// Throughput: one data byte per cycle unless stalled; 16 spare bytes/512-byte sector.
// The first spare byte is valid in the cycle after the 512th data byte is taken.
// The 512th byte of a sector stalls only while the previous spare area drains.
// Spare bytes leave the record register one per ready cycle, overlapped with input.
// Reset: synchronous active-low, clears position, accumulators and drain state.
module nand_sector_hamming_oob_core #(
    parameter int MARKER_INTERVAL = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nsho_in_if.sink     i_in,
    nsho_out_if.source  o_out
);

    // ECC record handed from the accumulator to the drain stage
    nsho_pkg::t_rec rec;
    logic           rec_valid;
    logic           rec_ready;

    // Accumulator: column parity is the XOR of per-byte patterns, line
    // parity the XOR of in-half indices of odd-parity bytes. The first
    // half's ECC is latched at byte 255; the second half's is formed
    // combinationally with byte 511 and goes straight to the drain.
    nsho_ecc_acc u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_rec       (rec),
        .o_rec_valid (rec_valid),
        .i_rec_ready (rec_ready)
    );

    // Drain: holds the record and serializes A0 A1 A2 B0 FF FF B1 B2 plus
    // the marker or fill bytes. Accepts a new record in the same cycle the last
    // spare byte is taken, so consecutive sectors do not stall while the
    // receiver keeps up.
    nsho_oob_drain #(
        .MARKER_INTERVAL (MARKER_INTERVAL)
    ) u_drain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (rec),
        .i_rec_valid (rec_valid),
        .o_rec_ready (rec_ready),
        .o_out       (o_out)
    );

endmodule

### test/tb_top.sv
// Self-checking testbench for the NAND sector spare-area (Hamming ECC + marker) generator.
module tb_top;

    localparam int MARKER_INTERVAL = 32;
    localparam int SECTOR_BYTES    = 512;
    localparam int RX_HOLD_CYCLES  = 1400;  // longer than a full sector at full rate
    localparam int STALL_LIMIT     = 6000;  // cycles without any transaction
    localparam int TAIL_CYCLES     = 24;    // spare output delay + 16 spare bytes + margin

    typedef logic [nsho_pkg::SECTOR_W-1:0] t_sector;

    // marker written into spare bytes 8..15 of every MARKER_INTERVAL-th sector
    localparam nsho_pkg::t_byte SECTOR_MARK [8] = '{8'h19, 8'h85, 8'h20, 8'h03,
                                                    8'h00, 8'h00, 8'h00, 8'h08};

    typedef enum int {
        FILL_RAMP,
        FILL_RANDOM
    } t_fill_kind;

    typedef struct packed {
        nsho_pkg::t_byte                value;
        logic [nsho_pkg::OOB_IDX_W-1:0] index;
        logic                           last;
    } t_spare_rec;

    logic i_clk;
    logic i_rst_n;

    nsho_in_if  in_if ();
    nsho_out_if out_if ();

    nand_sector_hamming_oob_core #(
        .MARKER_INTERVAL(MARKER_INTERVAL)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // ECC state mirrored from the accepted byte stream
    logic [nsho_pkg::POS_W-1:0] sect_pos;
    nsho_pkg::t_byte            col_acc;
    nsho_pkg::t_byte            line_acc;
    logic [23:0]                half_a_ecc;

    t_spare_rec pending_spare [$];

    int  fail_count;
    bit  idling_on;
    int  hold_req;
    int  hold_ack;
    int  rx_gap;
    int  quiet_cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------- prediction

    // column parity pattern: CP0/CP1 split on bit index bit 0, CP2/CP3 on bit 1,
    // CP4/CP5 on bit 2; bit 6 is the parity of the whole byte
    function automatic nsho_pkg::t_byte byte_columns(input nsho_pkg::t_byte b);
        nsho_pkg::t_byte pat;
        pat = '0;
        for (int j = 0; j < 8; j++) begin
            if (b[j]) begin
                pat[j & 1]              ^= 1'b1;
                pat[2 + ((j >> 1) & 1)] ^= 1'b1;
                pat[4 + ((j >> 2) & 1)] ^= 1'b1;
                pat[6]                  ^= 1'b1;
            end
        end
        return pat;
    endfunction

    // line parity bits interleaved odd/even (odd on the upper bit of each pair),
    // everything inverted; third byte is the inverted column parity over 2'b11
    function automatic logic [23:0] ecc_of_half(input nsho_pkg::t_byte cols,
                                                input nsho_pkg::t_byte lines);
        logic [15:0]     woven;
        nsho_pkg::t_byte flip;
        flip = cols[6] ? ~lines : lines;
        for (int n = 0; n < 8; n++) begin
            woven[2*n+1] = lines[n];
            woven[2*n]   = flip[n];
        end
        return {~woven, ~cols[5:0], 2'b11};
    endfunction

    task automatic predict_spare_area(input nsho_pkg::t_byte d, input t_sector sec);
        nsho_pkg::t_byte pat;
        logic [23:0]     half_b_ecc;
        nsho_pkg::t_byte area [16];
        t_spare_rec      rec;
        pat     = byte_columns(d);
        col_acc = col_acc ^ pat;
        if (pat[6])
            line_acc = line_acc ^ sect_pos[7:0];
        if (sect_pos == nsho_pkg::POS_HALF_END) begin
            half_a_ecc = ecc_of_half(col_acc, line_acc);
            col_acc    = '0;
            line_acc   = '0;
        end
        if (sect_pos != nsho_pkg::POS_LAST) begin
            sect_pos = sect_pos + 9'd1;
        end else begin
            half_b_ecc = ecc_of_half(col_acc, line_acc);
            col_acc    = '0;
            line_acc   = '0;
            sect_pos   = '0;
            area[nsho_pkg::SLOT_A0] = half_a_ecc[23:16];
            area[nsho_pkg::SLOT_A1] = half_a_ecc[15:8];
            area[nsho_pkg::SLOT_A2] = half_a_ecc[7:0];
            area[nsho_pkg::SLOT_B0] = half_b_ecc[23:16];
            area[nsho_pkg::SLOT_P0] = nsho_pkg::FILL_BYTE;
            area[nsho_pkg::SLOT_P1] = nsho_pkg::FILL_BYTE;
            area[nsho_pkg::SLOT_B1] = half_b_ecc[15:8];
            area[nsho_pkg::SLOT_B2] = half_b_ecc[7:0];
            for (int k = 0; k < 8; k++)
                area[8+k] = (sec % MARKER_INTERVAL == 0) ? SECTOR_MARK[k]
                                                         : nsho_pkg::FILL_BYTE;
            for (int k = 0; k < 16; k++) begin
                rec.value = area[k];
                rec.index = k[nsho_pkg::OOB_IDX_W-1:0];
                rec.last  = (k[nsho_pkg::OOB_IDX_W-1:0] == nsho_pkg::OOB_LAST);
                pending_spare.push_back(rec);
            end
        end
    endtask

    // ---------------------------------------------------------------- stimulus helpers

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_byte(input nsho_pkg::t_byte d, input t_sector sec);
        int gap;
        gap = idling_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.data_byte     <= d;
        in_if.sector_number <= sec;
        do @(posedge i_clk); while (!in_if.ready);
        predict_spare_area(d, sec);
    endtask

    task automatic send_sector(input t_fill_kind kind, input t_sector last_sec);
        nsho_pkg::t_byte d;
        t_sector         sec;
        for (int p = 0; p < SECTOR_BYTES; p++) begin
            case (kind)
                FILL_RAMP: d = p[8] ? ~p[7:0] : p[7:0];
                default:   d = nsho_pkg::t_byte'($urandom);
            endcase
            // earlier sector numbers are noise and must not leak into the marker
            sec = (p == SECTOR_BYTES - 1) ? last_sec : t_sector'($urandom);
            send_byte(d, sec);
        end
    endtask

    // sender stops until every predicted spare byte has come out
    task automatic wait_spare_drained();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_spare.size() != 0);
    endtask

    // ---------------------------------------------------------------- tests

    // idling on both sides; the last byte carries a marker sector number
    task automatic test_idle_gaps();
        idling_on = 1'b1;
        send_sector(FILL_RAMP, 16'd32);
    endtask

    // receiver held off right after the previous spare area is loaded, while the
    // next sector streams in at full rate, so its last byte has to wait
    task automatic test_spare_backpressure();
        idling_on = 1'b0;
        hold_req  = hold_req + 1;
        send_sector(FILL_RANDOM, 16'd31);
        idling_on = 1'b1;
    endtask

    // sender stops until both spare areas are out
    task automatic test_drain_pause();
        wait_spare_drained();
    endtask

    // ---------------------------------------------------------------- receiver side

    initial begin
        out_if.ready = 1'b0;
        rx_gap       = 0;
        hold_ack     = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_ack) begin
                hold_ack     = hold_req;
                rx_gap       = 0;
                out_if.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_gap > 0) begin
                out_if.ready <= 1'b0;
                rx_gap       = rx_gap - 1;
            end else begin
                rx_gap = idling_on ? pick_gap() : 0;
                if (rx_gap > 0) begin
                    out_if.ready <= 1'b0;
                    rx_gap       = rx_gap - 1;
                end else begin
                    out_if.ready <= 1'b1;
                end
            end
        end
    end

    // compare each spare byte transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_spare_rec exp_rec;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_spare.size() == 0) begin
                $error("unexpected spare byte %02h at index %0d", out_if.oob_byte,
                       out_if.oob_index);
                fail_count = fail_count + 1;
            end else begin
                exp_rec = pending_spare.pop_front();
                if (out_if.oob_byte !== exp_rec.value) begin
                    $error("oob_byte: expected %02h, got %02h", exp_rec.value,
                           out_if.oob_byte);
                    fail_count = fail_count + 1;
                end
                if (out_if.oob_index !== exp_rec.index) begin
                    $error("oob_index: expected %0d, got %0d", exp_rec.index,
                           out_if.oob_index);
                    fail_count = fail_count + 1;
                end
                if (out_if.oob_last !== exp_rec.last) begin
                    $error("oob_last: expected %0b, got %0b", exp_rec.last,
                           out_if.oob_last);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // watchdog: too long without a transaction on either channel
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.data_byte     = '0;
        in_if.sector_number = '0;
        sect_pos            = '0;
        col_acc             = '0;
        line_acc            = '0;
        half_a_ecc          = '0;
        fail_count          = 0;
        idling_on           = 1'b1;
        hold_req            = 0;
        quiet_cycles        = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_gaps();
        test_spare_backpressure();
        test_drain_pause();

        wait_spare_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_spare.size() != 0) begin
            $error("%0d spare bytes never arrived", pending_spare.size());
            fail_count = fail_count + 1;
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
